@@ rtl/lsa_pkg.sv @@
// shared types and constants of the linked slot allocator
package lsa_pkg;

   // beat field widths
   localparam int CMD_W     = 3;
   localparam int SLOT_W    = 6;
   localparam int PAY_W     = 32;
   localparam int STATUS_W  = 2;

   // command codes
   localparam logic [CMD_W-1:0] CMD_INSERT = 3'd0;
   localparam logic [CMD_W-1:0] CMD_FREE   = 3'd1;
   localparam logic [CMD_W-1:0] CMD_READ   = 3'd2;
   localparam logic [CMD_W-1:0] CMD_FIRST  = 3'd3;
   localparam logic [CMD_W-1:0] CMD_NEXT   = 3'd4;
   localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd5;

   // status codes
   localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_BAD  = 2'd2;

   // sentinel slots
   localparam int SLOT_USED_HEAD = 0;
   localparam int SLOT_USED_TAIL = 1;
   localparam int SLOT_FREE_HEAD = 2;
   localparam int SLOT_FREE_TAIL = 3;
   localparam int FIRST_DATA_SLOT = 4;

   // per-field write enables of the link memory
   typedef struct packed {
      logic next_en;
      logic prev_en;
      logic used_en;
   } link_wen_type;

endpackage

@@ rtl/lsa_ifs.sv @@
// request and response channel interfaces of the linked slot allocator
interface lsa_req_if;
   logic                            valid;
   logic                            ready;
   logic [lsa_pkg::CMD_W-1:0]       cmd;
   logic [lsa_pkg::SLOT_W-1:0]      slot_index;
   logic [lsa_pkg::PAY_W-1:0]       payload_in;

   modport source (output valid, cmd, slot_index, payload_in, input ready);
   modport sink   (input valid, cmd, slot_index, payload_in, output ready);
endinterface

interface lsa_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [lsa_pkg::STATUS_W-1:0]    status;
   logic [lsa_pkg::SLOT_W-1:0]      slot_out;
   logic [lsa_pkg::PAY_W-1:0]       payload_out;
   logic                            at_end;

   modport source (output valid, status, slot_out, payload_out, at_end, input ready);
   modport sink   (input valid, status, slot_out, payload_out, at_end, output ready);
endinterface

@@ rtl/lsa_link_mem.sv @@
// link memory: next link, prev link and in-use bit per slot, field write enables
module lsa_link_mem #(
   parameter int SLOTS = 64
) (
   input  logic                   clock,
   input  lsa_pkg::link_wen_type  wen,
   input  logic [$clog2(SLOTS)-1:0] waddr,
   input  logic [$clog2(SLOTS)-1:0] wnext,
   input  logic [$clog2(SLOTS)-1:0] wprev,
   input  logic                   wused,
   input  logic [$clog2(SLOTS)-1:0] raddr,
   output logic [$clog2(SLOTS)-1:0] rnext,
   output logic [$clog2(SLOTS)-1:0] rprev,
   output logic                   rused
);
   localparam int IW     = $clog2(SLOTS);
   localparam int WORD_W = 2 * IW + 1;

   logic [WORD_W-1:0] link_ff [SLOTS];
   logic [WORD_W-1:0] rdata_ff;

   // masked write
   always_ff @(posedge clock) begin
      if (wen.next_en) begin
         link_ff[waddr][IW-1:0] <= wnext;
      end
      if (wen.prev_en) begin
         link_ff[waddr][2*IW-1:IW] <= wprev;
      end
      if (wen.used_en) begin
         link_ff[waddr][2*IW] <= wused;
      end
   end

   // registered read
   always_ff @(posedge clock) begin
      rdata_ff <= link_ff[raddr];
   end

   assign rnext = rdata_ff[IW-1:0];
   assign rprev = rdata_ff[2*IW-1:IW];
   assign rused = rdata_ff[2*IW];
endmodule

@@ rtl/lsa_pay_mem.sv @@
// payload memory: one write port, one registered read port
module lsa_pay_mem #(
   parameter int SLOTS         = 64,
   parameter int PAYLOAD_WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(SLOTS)-1:0] waddr,
   input  logic [PAYLOAD_WIDTH-1:0] wdata,
   input  logic [$clog2(SLOTS)-1:0] raddr,
   output logic [PAYLOAD_WIDTH-1:0] rdata
);
   logic [PAYLOAD_WIDTH-1:0] pay_ff [SLOTS];
   logic [PAYLOAD_WIDTH-1:0] rdata_ff;

   // write port
   always_ff @(posedge clock) begin
      if (we) begin
         pay_ff[waddr] <= wdata;
      end
   end

   // registered read
   always_ff @(posedge clock) begin
      rdata_ff <= pay_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

@@ rtl/lsa_ctrl.sv @@
// command sequencer: list walks, link updates, clearing sweep and response register
module lsa_ctrl #(
   parameter int SLOTS         = 64,
   parameter int PAYLOAD_WIDTH = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   lsa_req_if.sink                   req,
   lsa_rsp_if.source                 rsp,
   // link memory
   output lsa_pkg::link_wen_type     lk_wen,
   output logic [$clog2(SLOTS)-1:0]  lk_waddr,
   output logic [$clog2(SLOTS)-1:0]  lk_wnext,
   output logic [$clog2(SLOTS)-1:0]  lk_wprev,
   output logic                      lk_wused,
   output logic [$clog2(SLOTS)-1:0]  lk_raddr,
   input  logic [$clog2(SLOTS)-1:0]  lk_rnext,
   input  logic [$clog2(SLOTS)-1:0]  lk_rprev,
   input  logic                      lk_rused,
   // payload memory
   output logic                      pm_we,
   output logic [$clog2(SLOTS)-1:0]  pm_waddr,
   output logic [PAYLOAD_WIDTH-1:0]  pm_wdata,
   output logic [$clog2(SLOTS)-1:0]  pm_raddr,
   input  logic [PAYLOAD_WIDTH-1:0]  pm_rdata
);
   localparam int IW = $clog2(SLOTS);
   localparam int SW = lsa_pkg::SLOT_W;
   localparam int OW = lsa_pkg::PAY_W;
   localparam int PW = PAYLOAD_WIDTH;

   localparam logic [IW-1:0] USED_HEAD = IW'(lsa_pkg::SLOT_USED_HEAD);
   localparam logic [IW-1:0] USED_TAIL = IW'(lsa_pkg::SLOT_USED_TAIL);
   localparam logic [IW-1:0] FREE_HEAD = IW'(lsa_pkg::SLOT_FREE_HEAD);
   localparam logic [IW-1:0] FREE_TAIL = IW'(lsa_pkg::SLOT_FREE_TAIL);
   localparam logic [IW-1:0] LAST_SLOT = IW'(SLOTS - 1);
   localparam logic [IW:0]   HW_RESET  = (IW + 1)'(lsa_pkg::FIRST_DATA_SLOT);

   // sequencer states
   localparam logic [4:0] ST_SWEEP    = 5'd0;
   localparam logic [4:0] ST_IDLE     = 5'd1;
   localparam logic [4:0] ST_INS_FH   = 5'd2;
   localparam logic [4:0] ST_INS_NXT  = 5'd3;
   localparam logic [4:0] ST_INS_TAIL = 5'd4;
   localparam logic [4:0] ST_INS_WS   = 5'd5;
   localparam logic [4:0] ST_INS_WP   = 5'd6;
   localparam logic [4:0] ST_INS_WT   = 5'd7;
   localparam logic [4:0] ST_FRE_CHK  = 5'd8;
   localparam logic [4:0] ST_FRE_TAIL = 5'd9;
   localparam logic [4:0] ST_FRE_WS   = 5'd10;
   localparam logic [4:0] ST_FRE_WQ   = 5'd11;
   localparam logic [4:0] ST_FRE_WT   = 5'd12;
   localparam logic [4:0] ST_RD_CHK   = 5'd13;
   localparam logic [4:0] ST_WALK_LNK = 5'd14;
   localparam logic [4:0] ST_WALK_PAY = 5'd15;
   localparam logic [4:0] ST_PUSH     = 5'd16;

   // control registers
   logic [4:0]                 state_ff, state_in;
   logic [IW-1:0]              cnt_ff, cnt_in;
   logic [IW:0]                hw_ff, hw_in;
   logic                       clr_pend_ff, clr_pend_in;
   logic                       rsp_valid_ff, rsp_valid_in;

   // working registers
   logic [lsa_pkg::CMD_W-1:0]  cmd_ff, cmd_in;
   logic [IW-1:0]              s_ff, s_in;
   logic [IW-1:0]              p_ff, p_in;
   logic [IW-1:0]              q_ff, q_in;
   logic [IW-1:0]              n1_ff, n1_in;
   logic                       from_free_ff, from_free_in;
   logic [PW-1:0]              pay_ff, pay_in;
   logic [lsa_pkg::STATUS_W-1:0] res_status_ff, res_status_in;
   logic [SW-1:0]              res_slot_ff, res_slot_in;
   logic [OW-1:0]              res_pay_ff, res_pay_in;
   logic                       res_end_ff, res_end_in;
   logic [lsa_pkg::STATUS_W-1:0] out_status_ff, out_status_in;
   logic [SW-1:0]              out_slot_ff, out_slot_in;
   logic [OW-1:0]              out_pay_ff, out_pay_in;
   logic                       out_end_ff, out_end_in;

   // width conversions
   logic [IW+SW-1:0]           idx_wide;
   logic [IW-1:0]              idx_iw;
   logic [PW+OW-1:0]           pin_wide;
   logic [PW-1:0]              pay_pw;
   logic [IW+SW-1:0]           s_wide;
   logic [SW-1:0]              s_slot;
   logic [IW+SW-1:0]           rn_wide;
   logic [SW-1:0]              rn_slot;
   logic [OW+PW-1:0]           pst_wide;
   logic [OW-1:0]              pst_out;
   logic [OW+PW-1:0]           prd_wide;
   logic [OW-1:0]              prd_out;
   logic                       idx_ok;
   logic                       walk_end;
   logic                       out_free;
   logic                       req_fire;

   assign idx_wide = {{IW{1'b0}}, req.slot_index};
   assign idx_iw   = idx_wide[IW-1:0];
   assign pin_wide = {{PW{1'b0}}, req.payload_in};
   assign pay_pw   = pin_wide[PW-1:0];
   assign s_wide   = {{SW{1'b0}}, s_ff};
   assign s_slot   = s_wide[SW-1:0];
   assign rn_wide  = {{SW{1'b0}}, lk_rnext};
   assign rn_slot  = rn_wide[SW-1:0];
   assign pst_wide = {{OW{1'b0}}, pay_ff};
   assign pst_out  = pst_wide[OW-1:0];
   assign prd_wide = {{OW{1'b0}}, pm_rdata};
   assign prd_out  = prd_wide[OW-1:0];

   // sentinels and out-of-range indexes are rejected up front
   assign idx_ok   = (req.slot_index >= SW'(lsa_pkg::FIRST_DATA_SLOT))
                     && ({26'd0, req.slot_index} < 32'(SLOTS));
   assign walk_end = (lk_rnext == USED_TAIL) || (32'(lk_rnext) >= 32'(SLOTS));
   assign out_free = !rsp_valid_ff || rsp.ready;
   assign req_fire = req.valid && (state_ff == ST_IDLE);

   assign req.ready       = (state_ff == ST_IDLE);
   assign rsp.valid       = rsp_valid_ff;
   assign rsp.status      = out_status_ff;
   assign rsp.slot_out    = out_slot_ff;
   assign rsp.payload_out = out_pay_ff;
   assign rsp.at_end      = out_end_ff;

   assign pm_waddr = s_ff;
   assign pm_wdata = pay_ff;

   // next-state and memory access logic
   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      hw_in         = hw_ff;
      clr_pend_in   = clr_pend_ff;
      cmd_in        = cmd_ff;
      s_in          = s_ff;
      p_in          = p_ff;
      q_in          = q_ff;
      n1_in         = n1_ff;
      from_free_in  = from_free_ff;
      pay_in        = pay_ff;
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;
      res_pay_in    = res_pay_ff;
      res_end_in    = res_end_ff;
      lk_wen        = '0;
      lk_waddr      = s_ff;
      lk_wnext      = '0;
      lk_wprev      = '0;
      lk_wused      = 1'b0;
      lk_raddr      = s_ff;
      pm_we         = 1'b0;
      pm_raddr      = s_ff;

      unique case (state_ff)
         // rewrite sentinel links and in-use bits, one slot a cycle
         ST_SWEEP: begin
            lk_wen   = '{next_en: 1'b1, prev_en: 1'b1, used_en: 1'b1};
            lk_waddr = cnt_ff;
            lk_wused = 1'b0;
            if (cnt_ff < IW'(lsa_pkg::FIRST_DATA_SLOT)) begin
               lk_wnext = {{(IW-2){1'b0}}, cnt_ff[1], 1'b1};
               lk_wprev = {{(IW-2){1'b0}}, cnt_ff[1], 1'b0};
            end
            cnt_in = cnt_ff + IW'(1);
            if (cnt_ff == LAST_SLOT) begin
               cnt_in      = '0;
               clr_pend_in = 1'b0;
               state_in    = clr_pend_ff ? ST_PUSH : ST_IDLE;
            end
         end

         // accept a command beat and issue its first read, if the command has one
         ST_IDLE: begin
            if (req_fire) begin
               cmd_in        = req.cmd;
               s_in          = idx_iw;
               pay_in        = pay_pw;
               res_status_in = lsa_pkg::STATUS_OK;
               res_slot_in   = '0;
               res_pay_in    = '0;
               res_end_in    = 1'b0;
               unique case (req.cmd)
                  lsa_pkg::CMD_INSERT: begin
                     lk_raddr = FREE_HEAD;
                     state_in = ST_INS_FH;
                  end
                  lsa_pkg::CMD_FREE: begin
                     if (idx_ok) begin
                        lk_raddr = idx_iw;
                        state_in = ST_FRE_CHK;
                     end else begin
                        res_status_in = lsa_pkg::STATUS_BAD;
                        state_in      = ST_PUSH;
                     end
                  end
                  lsa_pkg::CMD_READ: begin
                     if (idx_ok) begin
                        lk_raddr = idx_iw;
                        pm_raddr = idx_iw;
                        state_in = ST_RD_CHK;
                     end else begin
                        res_status_in = lsa_pkg::STATUS_BAD;
                        state_in      = ST_PUSH;
                     end
                  end
                  lsa_pkg::CMD_FIRST: begin
                     lk_raddr = USED_HEAD;
                     state_in = ST_WALK_LNK;
                  end
                  lsa_pkg::CMD_NEXT: begin
                     if (idx_ok) begin
                        lk_raddr = idx_iw;
                        state_in = ST_WALK_LNK;
                     end else begin
                        res_status_in = lsa_pkg::STATUS_BAD;
                        state_in      = ST_PUSH;
                     end
                  end
                  lsa_pkg::CMD_CLEAR: begin
                     cnt_in      = '0;
                     hw_in       = HW_RESET;
                     clr_pend_in = 1'b1;
                     state_in    = ST_SWEEP;
                  end
                  default: begin
                     state_in = ST_PUSH;
                  end
               endcase
            end
         end

         // insert: pick head of free list or next never-used slot, else report full
         ST_INS_FH: begin
            if (lk_rnext != FREE_TAIL) begin
               s_in     = lk_rnext;
               lk_raddr = lk_rnext;
               state_in = ST_INS_NXT;
            end else if (32'(hw_ff) < 32'(SLOTS)) begin
               s_in         = hw_ff[IW-1:0];
               hw_in        = hw_ff + (IW + 1)'(1);
               from_free_in = 1'b0;
               lk_raddr     = USED_TAIL;
               state_in     = ST_INS_TAIL;
            end else begin
               res_status_in = lsa_pkg::STATUS_FULL;
               state_in      = ST_PUSH;
            end
         end

         // unlink from free list head, fetch used tail prev
         ST_INS_NXT: begin
            n1_in        = lk_rnext;
            from_free_in = 1'b1;
            lk_wen       = '{next_en: 1'b1, prev_en: 1'b0, used_en: 1'b0};
            lk_waddr     = FREE_HEAD;
            lk_wnext     = lk_rnext;
            lk_raddr     = USED_TAIL;
            state_in     = ST_INS_TAIL;
         end

         ST_INS_TAIL: begin
            p_in = lk_rprev;
            if (from_free_ff) begin
               lk_wen   = '{next_en: 1'b0, prev_en: 1'b1, used_en: 1'b0};
               lk_waddr = n1_ff;
               lk_wprev = FREE_HEAD;
            end
            state_in = ST_INS_WS;
         end

         // new slot links and payload
         ST_INS_WS: begin
            lk_wen   = '{next_en: 1'b1, prev_en: 1'b1, used_en: 1'b1};
            lk_waddr = s_ff;
            lk_wnext = USED_TAIL;
            lk_wprev = p_ff;
            lk_wused = 1'b1;
            pm_we    = 1'b1;
            state_in = ST_INS_WP;
         end

         ST_INS_WP: begin
            lk_wen   = '{next_en: 1'b1, prev_en: 1'b0, used_en: 1'b0};
            lk_waddr = p_ff;
            lk_wnext = s_ff;
            state_in = ST_INS_WT;
         end

         ST_INS_WT: begin
            lk_wen     = '{next_en: 1'b0, prev_en: 1'b1, used_en: 1'b0};
            lk_waddr   = USED_TAIL;
            lk_wprev   = s_ff;
            res_slot_in = s_slot;
            res_pay_in  = pst_out;
            state_in   = ST_PUSH;
         end

         // free: check in-use, unlink from used list, fetch free tail prev
         ST_FRE_CHK: begin
            if (lk_rused) begin
               p_in     = lk_rprev;
               n1_in    = lk_rnext;
               lk_wen   = '{next_en: 1'b1, prev_en: 1'b0, used_en: 1'b0};
               lk_waddr = lk_rprev;
               lk_wnext = lk_rnext;
               lk_raddr = FREE_TAIL;
               state_in = ST_FRE_TAIL;
            end else begin
               res_status_in = lsa_pkg::STATUS_BAD;
               state_in      = ST_PUSH;
            end
         end

         ST_FRE_TAIL: begin
            q_in     = lk_rprev;
            lk_wen   = '{next_en: 1'b0, prev_en: 1'b1, used_en: 1'b0};
            lk_waddr = n1_ff;
            lk_wprev = p_ff;
            state_in = ST_FRE_WS;
         end

         // append to free list tail
         ST_FRE_WS: begin
            lk_wen   = '{next_en: 1'b1, prev_en: 1'b1, used_en: 1'b1};
            lk_waddr = s_ff;
            lk_wnext = FREE_TAIL;
            lk_wprev = q_ff;
            lk_wused = 1'b0;
            state_in = ST_FRE_WQ;
         end

         ST_FRE_WQ: begin
            lk_wen   = '{next_en: 1'b1, prev_en: 1'b0, used_en: 1'b0};
            lk_waddr = q_ff;
            lk_wnext = s_ff;
            state_in = ST_FRE_WT;
         end

         ST_FRE_WT: begin
            lk_wen      = '{next_en: 1'b0, prev_en: 1'b1, used_en: 1'b0};
            lk_waddr    = FREE_TAIL;
            lk_wprev    = s_ff;
            res_slot_in = s_slot;
            state_in    = ST_PUSH;
         end

         // read: payload is valid only for a slot in use
         ST_RD_CHK: begin
            if (lk_rused) begin
               res_slot_in = s_slot;
               res_pay_in  = prd_out;
            end else begin
               res_status_in = lsa_pkg::STATUS_BAD;
            end
            state_in = ST_PUSH;
         end

         // walk: step along next link, stop at used tail or an out-of-range link
         ST_WALK_LNK: begin
            if ((cmd_ff == lsa_pkg::CMD_NEXT) && !lk_rused) begin
               res_status_in = lsa_pkg::STATUS_BAD;
               state_in      = ST_PUSH;
            end else if (walk_end) begin
               res_end_in = 1'b1;
               state_in   = ST_PUSH;
            end else begin
               s_in        = lk_rnext;
               res_slot_in = rn_slot;
               pm_raddr    = lk_rnext;
               state_in    = ST_WALK_PAY;
            end
         end

         ST_WALK_PAY: begin
            res_pay_in = prd_out;
            state_in   = ST_PUSH;
         end

         // hand the result to the response register
         ST_PUSH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // response register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      out_status_in = out_status_ff;
      out_slot_in   = out_slot_ff;
      out_pay_in    = out_pay_ff;
      out_end_in    = out_end_ff;
      if ((state_ff == ST_PUSH) && out_free) begin
         rsp_valid_in  = 1'b1;
         out_status_in = res_status_ff;
         out_slot_in   = res_slot_ff;
         out_pay_in    = res_pay_ff;
         out_end_in    = res_end_ff;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SWEEP;
         cnt_ff       <= '0;
         hw_ff        <= HW_RESET;
         clr_pend_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         hw_ff        <= hw_in;
         clr_pend_ff  <= clr_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working and payload registers
   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      s_ff          <= s_in;
      p_ff          <= p_in;
      q_ff          <= q_in;
      n1_ff         <= n1_in;
      from_free_ff  <= from_free_in;
      pay_ff        <= pay_in;
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      res_pay_ff    <= res_pay_in;
      res_end_ff    <= res_end_in;
      out_status_ff <= out_status_in;
      out_slot_ff   <= out_slot_in;
      out_pay_ff    <= out_pay_in;
      out_end_ff    <= out_end_in;
   end
endmodule

@@ rtl/linked_slot_allocator_top.sv @@
// top level of the linked slot allocator: sequencer, link memory and payload memory
//
//   channel    dir   port       fields
//   request    in    req_chan   cmd, slot_index, payload_in
//   response   out   rsp_chan   status, slot_out, payload_out, at_end
//
// one command at a time; insert and free apply their link updates one after another,
// since the link memory has a single write port.
// after reset and on clear a sweep over all SLOTS slots rewrites sentinels and in-use bits.
// a response beat waits in its output register while the next request is taken;
// a later result holds the sequencer until that register drains.
module linked_slot_allocator_top #(
   parameter int SLOTS         = 64,
   parameter int PAYLOAD_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   lsa_req_if.sink     req_chan,
   lsa_rsp_if.source   rsp_chan
);
   localparam int IW = $clog2(SLOTS);

   lsa_pkg::link_wen_type     lk_wen;
   logic [IW-1:0]             lk_waddr;
   logic [IW-1:0]             lk_wnext;
   logic [IW-1:0]             lk_wprev;
   logic                      lk_wused;
   logic [IW-1:0]             lk_raddr;
   logic [IW-1:0]             lk_rnext;
   logic [IW-1:0]             lk_rprev;
   logic                      lk_rused;
   logic                      pm_we;
   logic [IW-1:0]             pm_waddr;
   logic [PAYLOAD_WIDTH-1:0]  pm_wdata;
   logic [IW-1:0]             pm_raddr;
   logic [PAYLOAD_WIDTH-1:0]  pm_rdata;

   // command sequencer
   lsa_ctrl #(
      .SLOTS         (SLOTS),
      .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req      (req_chan),
      .rsp      (rsp_chan),
      .lk_wen   (lk_wen),
      .lk_waddr (lk_waddr),
      .lk_wnext (lk_wnext),
      .lk_wprev (lk_wprev),
      .lk_wused (lk_wused),
      .lk_raddr (lk_raddr),
      .lk_rnext (lk_rnext),
      .lk_rprev (lk_rprev),
      .lk_rused (lk_rused),
      .pm_we    (pm_we),
      .pm_waddr (pm_waddr),
      .pm_wdata (pm_wdata),
      .pm_raddr (pm_raddr),
      .pm_rdata (pm_rdata)
   );

   // link memory
   lsa_link_mem #(
      .SLOTS (SLOTS)
   ) u_link_mem (
      .clock (clock),
      .wen   (lk_wen),
      .waddr (lk_waddr),
      .wnext (lk_wnext),
      .wprev (lk_wprev),
      .wused (lk_wused),
      .raddr (lk_raddr),
      .rnext (lk_rnext),
      .rprev (lk_rprev),
      .rused (lk_rused)
   );

   // payload memory
   lsa_pay_mem #(
      .SLOTS         (SLOTS),
      .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
   ) u_pay_mem (
      .clock (clock),
      .we    (pm_we),
      .waddr (pm_waddr),
      .wdata (pm_wdata),
      .raddr (pm_raddr),
      .rdata (pm_rdata)
   );
endmodule
